// ===== design/keyed_xor_text_stream_scrambler_macros.svh =====
// ----------------------------------------------------------------------------
// keyed xor text stream scrambler assertion macros
// shared concurrent assertion forms for the scrambler top level
// ----------------------------------------------------------------------------
`ifndef KEYED_XOR_TEXT_STREAM_SCRAMBLER_MACROS_SVH
`define KEYED_XOR_TEXT_STREAM_SCRAMBLER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define KXS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define KXS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/kxs_pkg.sv =====
// ----------------------------------------------------------------------------
// kxs_pkg
// types and constants shared by the keyed xor text stream scrambler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kxs_pkg;

   localparam int TEXT_DEPTH_DEF = 1024;
   localparam int VALUE_W        = 8;
   localparam int POS_W          = 10;
   localparam int ACT_W          = 2;

   localparam logic [VALUE_W-1:0] NUL_CHAR = 8'h00;

   typedef enum logic [ACT_W-1:0] {
      ACT_LOAD  = 2'd0,
      ACT_START = 2'd1,
      ACT_DATA  = 2'd2
   } act_type;

endpackage

// ===== design/kxs_text_ram.sv =====
// ----------------------------------------------------------------------------
// kxs_text_ram
// text store, one write port and one registered read port with write bypass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kxs_text_ram
   import kxs_pkg::*;
#(
   parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
   localparam int AW = $clog2(TEXT_DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]      rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [TEXT_DEPTH];
   logic [VALUE_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

// ===== design/kxs_key_unit.sv =====
// ----------------------------------------------------------------------------
// kxs_key_unit
// running key, text walk index and byte parity, with next-character prefetch
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kxs_key_unit
   import kxs_pkg::*;
#(
   parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
   localparam int AW = $clog2(TEXT_DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  act_type            action,
   input  logic [VALUE_W-1:0] value,
   input  logic [POS_W-1:0]   position,
   input  logic [VALUE_W-1:0] rd_data,
   output logic [AW-1:0]      rd_addr,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [VALUE_W-1:0] wr_data,
   output logic [VALUE_W-1:0] data_out
);

   logic [VALUE_W-1:0] key_ff, key_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               odd_ff, odd_in;
   logic [VALUE_W-1:0] char0_ff, char0_in;

   logic [31:0]        pos_wide;
   logic               pos_ok;
   logic               is_nul;
   logic [VALUE_W-1:0] ch;
   logic [VALUE_W-1:0] ch_shift;
   logic [VALUE_W-1:0] key_data;
   logic [AW:0]        idx_inc;
   logic [AW-1:0]      idx_step;

   always_comb begin
      pos_wide = 32'(position);
      pos_ok   = pos_wide < 32'(TEXT_DEPTH);
      is_nul   = rd_data == NUL_CHAR;
      ch       = is_nul ? char0_ff : rd_data;
      ch_shift = odd_ff ? {ch[VALUE_W-2:0], 1'b0} : ch;
      key_data = key_ff ^ ch_shift;
      idx_inc  = {1'b0, idx_ff} + (AW+1)'(1);
      idx_step = (idx_inc == (AW+1)'(TEXT_DEPTH)) ? '0 : idx_inc[AW-1:0];
      data_out = value ^ key_data;

      key_in   = key_ff;
      idx_in   = idx_ff;
      odd_in   = odd_ff;
      char0_in = char0_ff;
      wr_en    = 1'b0;
      wr_addr  = pos_wide[AW-1:0];
      wr_data  = value;

      if (fire) begin
         case (action)
            ACT_LOAD: begin
               wr_en = pos_ok;
               if (pos_wide == 32'd0) begin
                  char0_in = value;
               end
            end
            ACT_START: begin
               key_in = value;
               idx_in = '0;
               odd_in = 1'b0;
            end
            ACT_DATA: begin
               key_in = key_data;
               idx_in = is_nul ? AW'(1) : idx_step;
               odd_in = ~odd_ff;
            end
            default: begin
            end
         endcase
      end

      rd_addr = idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         idx_ff <= '0;
         odd_ff <= 1'b0;
      end else begin
         key_ff <= key_in;
         idx_ff <= idx_in;
         odd_ff <= odd_in;
      end
   end

   always_ff @(posedge clock) begin
      char0_ff <= char0_in;
   end

endmodule

// ===== design/keyed_xor_text_stream_scrambler.sv =====
// ----------------------------------------------------------------------------
// keyed_xor_text_stream_scrambler
// scrambles or unscrambles packet bytes with a running xor key from stored text
// ----------------------------------------------------------------------------
// One beat is taken every cycle, loads and starts included, as long as the
// result side keeps up. A data beat passes through the input register and then
// the result register before it is offered on the result side. While a
// result is held, a data beat waiting in the input register stalls the input;
// loads and starts still pass. The pace is set by the single registered read
// port of the text store: the character for the next data byte is read ahead
// in the cycle the current byte is worked, and entry 0 is mirrored in a
// register so a NUL costs no second read. The text store has no reset and no
// clearing pass; every entry that a walk reaches must have been loaded first.
`timescale 1ns / 1ps
`include "keyed_xor_text_stream_scrambler_macros.svh"

module keyed_xor_text_stream_scrambler
   import kxs_pkg::*;
#(
   parameter int TEXT_DEPTH = TEXT_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [ACT_W-1:0]   req_action,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [POS_W-1:0]   req_position,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_data_out,
   output logic               rsp_last_out
);

   localparam int AW = $clog2(TEXT_DEPTH);

   logic               s1_valid_ff, s1_valid_in;
   act_type            s1_action_ff;
   logic [VALUE_W-1:0] s1_value_ff;
   logic [POS_W-1:0]   s1_position_ff;
   logic               s1_last_ff;

   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_data_ff;
   logic               out_last_ff;

   logic               req_accept;
   logic               out_free;
   logic               s1_fire;
   logic               s1_data_fire;

   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [VALUE_W-1:0] key_data_out;

   always_comb begin
      out_free     = ~out_valid_ff | ~rsp_stall;
      s1_fire      = s1_valid_ff & ((s1_action_ff != ACT_DATA) | out_free);
      s1_data_fire = s1_fire & (s1_action_ff == ACT_DATA);
      req_stall    = s1_valid_ff & ~s1_fire;
      req_accept   = req_valid & ~req_stall;
      s1_valid_in  = req_accept | (s1_valid_ff & ~s1_fire);

      if (s1_data_fire) begin
         out_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // input beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff   <= act_type'(req_action);
         s1_value_ff    <= req_value;
         s1_position_ff <= req_position;
         s1_last_ff     <= req_last_byte;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_data_fire) begin
         out_data_ff <= key_data_out;
         out_last_ff <= s1_last_ff;
      end
   end

   kxs_key_unit #(
      .TEXT_DEPTH (TEXT_DEPTH)
   ) u_key_unit (
      .clock    (clock),
      .reset    (reset),
      .fire     (s1_fire),
      .action   (s1_action_ff),
      .value    (s1_value_ff),
      .position (s1_position_ff),
      .rd_data  (rd_data),
      .rd_addr  (rd_addr),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .data_out (key_data_out)
   );

   kxs_text_ram #(
      .TEXT_DEPTH (TEXT_DEPTH)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid    = out_valid_ff;
   assign rsp_data_out = out_data_ff;
   assign rsp_last_out = out_last_ff;

   `KXS_ASSERT_NEXT(a_data_gives_beat, clock, reset, s1_data_fire, out_valid_ff, "data beat lost")
   `KXS_ASSERT_NEXT(a_no_extra_beat, clock, reset, s1_fire && (s1_action_ff != ACT_DATA) && out_free, !out_valid_ff, "result beat invented")
   `KXS_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, s1_valid_ff && (s1_action_ff == ACT_DATA) && out_valid_ff && rsp_stall, "input stalled without cause")

endmodule
